// ===== hdl/acr_pkg.sv =====
// Shared constants, types and register codes of the ADC-to-RGBA colour ramp.
// Used by every file of the block; depends on nothing.
package acr_pkg;

  // Sizes of the ramp and of the position format.
  localparam int MAX_STOPS     = 6;
  localparam int POS_FRAC_BITS = 16;
  localparam int POS_W         = POS_FRAC_BITS + 1;

  // Field widths.
  localparam int SAMPLE_W  = 16;
  localparam int RAW_W     = SAMPLE_W - 1;
  localparam int FS_W      = 15;
  localparam int CNT_W     = 3;
  localparam int CHAN_W    = 8;
  localparam int NUM_CHANS = 4;
  localparam int COLOR_W   = CHAN_W * NUM_CHANS;
  localparam int STOP_W    = COLOR_W + POS_W;
  localparam int IDX_W     = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = STOP_W;

  // Datapath widths.
  localparam int REM_W = FS_W + 1;
  localparam int MUL_W = CHAN_W + POS_W;
  localparam int DVD_W = MUL_W + 2;
  localparam int DVS_W = POS_W + 1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_STOP_FIRST = CFG_IDX_W'(2);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CHAN_W-1:0] chan_t;
  // Index NUM_CHANS-1 is red, index 0 is alpha, matching the stop packing.
  typedef chan_t [NUM_CHANS-1:0] color_t;

  typedef struct packed {
    pos_t   pos;
    color_t color;
  } stop_t;

  typedef stop_t [MAX_STOPS-1:0] stop_set_t;

  // Division request for the four channel lanes.
  typedef struct packed {
    logic [DVS_W-1:0]                  dvs;
    logic [NUM_CHANS-1:0][DVD_W-1:0]   dvd;
  } div_req_t;

  localparam pos_t POS_ONE = pos_t'(1) << POS_FRAC_BITS;
  localparam pos_t POS_MAX = '1;

  // Reset values.
  localparam logic [CNT_W-1:0] STOP_COUNT_RST = CNT_W'(2);
  localparam logic [FS_W-1:0]  FULL_SCALE_RST = FS_W'(4095);
  localparam stop_t            STOP_1_RST     = '{pos: POS_ONE, color: '1};
  // Whole stop set after reset: the second stop is white at 1.0, all else zero.
  localparam stop_set_t        STOPS_RST      = stop_set_t'(STOP_1_RST) << STOP_W;

endpackage

// ===== hdl/acr_cfg_if.sv =====
// Configuration write channel of the colour ramp.
// Depends on acr_pkg.
interface acr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [acr_pkg::CFG_IDX_W-1:0]   index;
  logic [acr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

// ===== hdl/acr_sample_if.sv =====
// Sample input channel of the colour ramp: one signed ADC value per item.
// Depends on acr_pkg.
interface acr_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [acr_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
  modport monitor (input valid, ready, sample);
endinterface

// ===== hdl/acr_pixel_if.sv =====
// Colour output channel of the colour ramp: one RGBA pixel per item.
// Depends on acr_pkg.
interface acr_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [acr_pkg::CHAN_W-1:0]  red;
  logic [acr_pkg::CHAN_W-1:0]  green;
  logic [acr_pkg::CHAN_W-1:0]  blue;
  logic [acr_pkg::CHAN_W-1:0]  alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
  modport monitor (input valid, ready, red, green, blue, alpha);
endinterface

// ===== hdl/acr_pos_div.sv =====
// Pipelined restoring divider that turns a sample into a saturated position.
// One quotient bit per stage; depends on acr_pkg.
module acr_pos_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [acr_pkg::SAMPLE_W-1:0] sample,
  input  logic [acr_pkg::FS_W-1:0]            fs,
  output logic                                out_valid,
  input  logic                                out_ready,
  output acr_pkg::pos_t                       z
);

  localparam int STAGES = acr_pkg::POS_W;

  logic [STAGES-1:0]        vld;
  logic [STAGES:0]          rdy;
  logic [acr_pkg::REM_W-1:0] rem [STAGES];
  acr_pkg::pos_t             quo [STAGES];
  logic [STAGES-1:0]        sat;

  logic [acr_pkg::REM_W-1:0] raw_ext;
  logic [acr_pkg::REM_W-1:0] fs_ext;
  logic                      sat0;
  logic                      top_bit;

  // A stage can take an item when it is empty or its item moves on.
  assign rdy[STAGES] = out_ready;
  for (genvar k = 0; k < STAGES; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  // First stage: negative samples become zero, overflow is detected up front
  // (quotient reaches two exactly when the sample is at least twice the full
  // scale), and the top quotient bit is decided.
  assign raw_ext = sample[acr_pkg::SAMPLE_W-1] ? '0 :
                   acr_pkg::REM_W'(sample[acr_pkg::RAW_W-1:0]);
  assign fs_ext  = acr_pkg::REM_W'(fs);
  assign sat0    = raw_ext >= {fs, 1'b0};
  assign top_bit = raw_ext >= fs_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      rem[0] <= top_bit ? raw_ext - fs_ext : raw_ext;
      quo[0] <= acr_pkg::pos_t'(top_bit) << (STAGES - 1);
      sat[0] <= sat0;
    end
  end

  // Remaining stages: shift the remainder, compare, subtract.
  for (genvar k = 1; k < STAGES; k++) begin : g_stage
    logic [acr_pkg::REM_W-1:0] sh;
    logic                      take;

    assign sh   = {rem[k-1][acr_pkg::REM_W-2:0], 1'b0};
    assign take = sh >= fs_ext;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vld[k-1]) begin
        rem[k] <= take ? sh - fs_ext : sh;
        quo[k] <= quo[k-1] | (acr_pkg::pos_t'(take) << (STAGES - 1 - k));
        sat[k] <= sat[k-1];
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign z         = sat[STAGES-1] ? acr_pkg::POS_MAX : quo[STAGES-1];

endmodule

// ===== hdl/acr_seg.sv =====
// Stop search, weight computation and channel products of the colour ramp.
// Four register stages feeding the channel dividers; depends on acr_pkg.
module acr_seg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  acr_pkg::pos_t                 z,
  input  acr_pkg::stop_set_t            stops,
  input  logic [acr_pkg::IDX_W-1:0]     last_idx,
  output logic                          out_valid,
  input  logic                          out_ready,
  output acr_pkg::div_req_t             req
);

  localparam int STAGES = 4;

  logic [STAGES-1:0] vld;
  logic [STAGES:0]   rdy;

  assign rdy[STAGES] = out_ready;
  for (genvar k = 0; k < STAGES; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Stage A: find the enclosing pair of stops. At either end the segment is
  // replaced by positions 0 and 1 with the point at 1, which reproduces the
  // end stop's colour exactly through the interpolation.
  logic                       at_first;
  logic                       at_last;
  logic [acr_pkg::IDX_W-1:0]  up_idx;
  logic [acr_pkg::IDX_W-1:0]  lo_idx;
  acr_pkg::color_t            sel_lo;
  acr_pkg::color_t            sel_hi;
  acr_pkg::pos_t              sel_z0;
  acr_pkg::pos_t              sel_z1;
  acr_pkg::pos_t              sel_z;

  assign at_first = z <= stops[0].pos;
  assign at_last  = z >= stops[last_idx].pos;

  always_comb begin
    up_idx = last_idx;
    for (int i = acr_pkg::MAX_STOPS - 2; i >= 1; i--) begin
      if (acr_pkg::IDX_W'(i) < last_idx && stops[i].pos >= z) begin
        up_idx = acr_pkg::IDX_W'(i);
      end
    end
  end

  assign lo_idx = up_idx - acr_pkg::IDX_W'(1);

  always_comb begin
    if (at_first) begin
      sel_lo = stops[0].color;
      sel_hi = stops[0].color;
      sel_z0 = '0;
      sel_z1 = acr_pkg::pos_t'(1);
      sel_z  = acr_pkg::pos_t'(1);
    end else if (at_last) begin
      sel_lo = stops[last_idx].color;
      sel_hi = stops[last_idx].color;
      sel_z0 = '0;
      sel_z1 = acr_pkg::pos_t'(1);
      sel_z  = acr_pkg::pos_t'(1);
    end else begin
      sel_lo = stops[lo_idx].color;
      sel_hi = stops[up_idx].color;
      sel_z0 = stops[lo_idx].pos;
      sel_z1 = stops[up_idx].pos;
      sel_z  = z;
    end
  end

  acr_pkg::color_t a_lo, a_hi;
  acr_pkg::pos_t   a_z0, a_z1, a_z;

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      a_lo <= sel_lo;
      a_hi <= sel_hi;
      a_z0 <= sel_z0;
      a_z1 <= sel_z1;
      a_z  <= sel_z;
    end
  end

  // Stage B: weights of the two stops and the segment span.
  acr_pkg::color_t b_lo, b_hi;
  acr_pkg::pos_t   b_wlo, b_whi, b_span;

  always_ff @(posedge clk) begin
    if (rdy[1] && vld[0]) begin
      b_lo   <= a_lo;
      b_hi   <= a_hi;
      b_wlo  <= a_z1 - a_z;
      b_whi  <= a_z - a_z0;
      b_span <= a_z1 - a_z0;
    end
  end

  // Stage C: one product per stop and channel.
  logic [acr_pkg::NUM_CHANS-1:0][acr_pkg::MUL_W-1:0] c_plo, c_phi;
  acr_pkg::pos_t                                     c_span;

  always_ff @(posedge clk) begin
    if (rdy[2] && vld[1]) begin
      for (int c = 0; c < acr_pkg::NUM_CHANS; c++) begin
        c_plo[c] <= acr_pkg::MUL_W'(b_lo[c]) * acr_pkg::MUL_W'(b_wlo);
        c_phi[c] <= acr_pkg::MUL_W'(b_hi[c]) * acr_pkg::MUL_W'(b_whi);
      end
      c_span <= b_span;
    end
  end

  // Stage D: rounding dividend 2*num + span over divisor 2*span.
  logic [acr_pkg::NUM_CHANS-1:0][acr_pkg::MUL_W:0] c_sum;

  always_comb begin
    for (int c = 0; c < acr_pkg::NUM_CHANS; c++) begin
      c_sum[c] = (acr_pkg::MUL_W + 1)'(c_plo[c]) + (acr_pkg::MUL_W + 1)'(c_phi[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3] && vld[2]) begin
      for (int c = 0; c < acr_pkg::NUM_CHANS; c++) begin
        req.dvd[c] <= acr_pkg::DVD_W'({c_sum[c], 1'b0}) + acr_pkg::DVD_W'(c_span);
      end
      req.dvs <= {c_span, 1'b0};
    end
  end

  assign out_valid = vld[STAGES-1];

endmodule

// ===== hdl/acr_chan_div.sv =====
// Four-lane pipelined restoring divider giving the rounded channel values.
// One quotient bit per stage across all lanes; depends on acr_pkg.
module acr_chan_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  acr_pkg::div_req_t req,
  output logic              out_valid,
  input  logic              out_ready,
  output acr_pkg::color_t   color
);

  localparam int STAGES = acr_pkg::CHAN_W;

  logic [STAGES-1:0] vld;
  logic [STAGES:0]   rdy;

  logic [acr_pkg::NUM_CHANS-1:0][acr_pkg::DVD_W-1:0] rem [STAGES];
  logic [acr_pkg::DVS_W-1:0]                         dvs [STAGES];
  acr_pkg::color_t                                   quo [STAGES];

  assign rdy[STAGES] = out_ready;
  for (genvar k = 0; k < STAGES; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                                              src_vld;
    logic [acr_pkg::NUM_CHANS-1:0][acr_pkg::DVD_W-1:0] src_rem;
    logic [acr_pkg::DVS_W-1:0]                         src_dvs;
    acr_pkg::color_t                                   src_quo;
    logic [acr_pkg::DVD_W-1:0]                         shifted;
    logic [acr_pkg::NUM_CHANS-1:0][acr_pkg::DVD_W-1:0] nxt_rem;
    acr_pkg::color_t                                   nxt_quo;

    // Stage zero takes the request, later stages the previous stage.
    if (k == 0) begin : g_head
      assign src_vld = in_valid;
      assign src_rem = req.dvd;
      assign src_dvs = req.dvs;
      assign src_quo = '0;
    end else begin : g_body
      assign src_vld = vld[k-1];
      assign src_rem = rem[k-1];
      assign src_dvs = dvs[k-1];
      assign src_quo = quo[k-1];
    end

    assign shifted = acr_pkg::DVD_W'(src_dvs) << (STAGES - 1 - k);

    // Trial subtraction in each lane.
    for (genvar c = 0; c < acr_pkg::NUM_CHANS; c++) begin : g_lane
      logic take;
      assign take       = src_rem[c] >= shifted;
      assign nxt_rem[c] = take ? src_rem[c] - shifted : src_rem[c];
      assign nxt_quo[c] = src_quo[c] | (acr_pkg::chan_t'(take) << (STAGES - 1 - k));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_vld) begin
        rem[k] <= nxt_rem;
        dvs[k] <= src_dvs;
        quo[k] <= nxt_quo;
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign color     = quo[STAGES-1];

endmodule

// ===== hdl/adc_to_rgba_color_ramp_unit.sv =====
// Top level of the ADC-to-RGBA colour ramp: configuration registers and the
// three pipeline sections. Depends on acr_pkg, the channel interfaces,
// acr_pos_div, acr_seg and acr_chan_div.
//
//   Channel  Role    Payload                       Accepted when
//   -------  ------  ----------------------------  -----------------------
//   cfg      sink    index (4 b), data (49 b)      cfg.valid && cfg.ready
//   adc      sink    sample (16 b, signed)         adc.valid && adc.ready
//   pixel    source  red, green, blue, alpha (8 b) pixel.valid && pixel.ready
//
// One item enters per clock while the output takes pixels; an item passes from
// acceptance to its pixel through the position divider (17), the search and
// multiply section (4) and the channel dividers (8), with one quotient bit per
// stage in each divider. Each stage holds its item while the next one is full, so
// bubbles close up under a stalled output. Synchronous reset empties the
// pipeline and loads the default ramp; cfg.ready is always high.
module adc_to_rgba_color_ramp_unit (
  input  logic         clk,
  input  logic         rst,
  acr_cfg_if.sink      cfg,
  acr_sample_if.sink   adc,
  acr_pixel_if.source  pixel
);

  logic [acr_pkg::CNT_W-1:0] stop_count;
  logic [acr_pkg::FS_W-1:0]  full_scale;
  acr_pkg::stop_set_t        stops;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= acr_pkg::STOP_COUNT_RST;
      full_scale <= acr_pkg::FULL_SCALE_RST;
      stops      <= acr_pkg::STOPS_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        acr_pkg::REG_STOP_COUNT: begin
          stop_count <= cfg.data[acr_pkg::CNT_W-1:0];
        end
        acr_pkg::REG_FULL_SCALE: begin
          full_scale <= cfg.data[acr_pkg::FS_W-1:0];
        end
        default: begin
          for (int i = 0; i < acr_pkg::MAX_STOPS; i++) begin
            if (cfg.index == acr_pkg::REG_STOP_FIRST + acr_pkg::CFG_IDX_W'(i)) begin
              stops[i] <= acr_pkg::stop_t'(cfg.data);
            end
          end
        end
      endcase
    end
  end

  // A zero full scale counts as one; the stop count is held to 1..MAX_STOPS.
  logic [acr_pkg::FS_W-1:0]  fs_eff;
  logic [acr_pkg::IDX_W-1:0] last_idx;

  assign fs_eff = (full_scale == '0) ? acr_pkg::FS_W'(1) : full_scale;

  always_comb begin
    if (stop_count == '0) begin
      last_idx = '0;
    end else if (stop_count > acr_pkg::CNT_W'(acr_pkg::MAX_STOPS)) begin
      last_idx = acr_pkg::IDX_W'(acr_pkg::MAX_STOPS - 1);
    end else begin
      last_idx = acr_pkg::IDX_W'(stop_count - acr_pkg::CNT_W'(1));
    end
  end

  // Pipeline sections.
  logic              pos_valid, pos_ready;
  acr_pkg::pos_t     pos_z;
  logic              req_valid, req_ready;
  acr_pkg::div_req_t req;
  acr_pkg::color_t   color;

  acr_pos_div u_pos_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (adc.valid),
    .in_ready  (adc.ready),
    .sample    (adc.sample),
    .fs        (fs_eff),
    .out_valid (pos_valid),
    .out_ready (pos_ready),
    .z         (pos_z)
  );

  acr_seg u_seg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pos_valid),
    .in_ready  (pos_ready),
    .z         (pos_z),
    .stops     (stops),
    .last_idx  (last_idx),
    .out_valid (req_valid),
    .out_ready (req_ready),
    .req       (req)
  );

  acr_chan_div u_chan_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_ready  (req_ready),
    .req       (req),
    .out_valid (pixel.valid),
    .out_ready (pixel.ready),
    .color     (color)
  );

  assign pixel.red   = color[3];
  assign pixel.green = color[2];
  assign pixel.blue  = color[1];
  assign pixel.alpha = color[0];

endmodule

// ===== hdl/acr_checker.sv =====
// Port-level checks of the colour ramp and the bind that attaches them.
// Depends on acr_pkg and adc_to_rgba_color_ramp_unit.
module acr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cfg_ready,
  input logic                       adc_ready,
  input logic                       pixel_valid,
  input logic                       pixel_ready,
  input logic [acr_pkg::CHAN_W-1:0] pixel_red,
  input logic [acr_pkg::CHAN_W-1:0] pixel_green,
  input logic [acr_pkg::CHAN_W-1:0] pixel_blue,
  input logic [acr_pkg::CHAN_W-1:0] pixel_alpha
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !pixel_valid)
    else $error("pixel valid after reset");

  // When the output stage is free, every stage can move, so input is taken.
  a_input_open: assert property (@(posedge clk) disable iff (rst)
    (!pixel_valid || pixel_ready) |-> adc_ready)
    else $error("input stalled with a free output stage");

  // A stalled pixel is held.
  a_pixel_hold: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_ready) |=> (pixel_valid && $stable(pixel_red) &&
      $stable(pixel_green) && $stable(pixel_blue) && $stable(pixel_alpha)))
    else $error("stalled pixel changed");

  // Configuration writes are never refused.
  a_cfg_open: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind adc_to_rgba_color_ramp_unit acr_checker u_acr_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_ready   (cfg.ready),
  .adc_ready   (adc.ready),
  .pixel_valid (pixel.valid),
  .pixel_ready (pixel.ready),
  .pixel_red   (pixel.red),
  .pixel_green (pixel.green),
  .pixel_blue  (pixel.blue),
  .pixel_alpha (pixel.alpha)
);

// ===== verif/tb.sv =====
// Self-checking bench for the ADC-to-RGBA colour ramp: a directed table and
// randomised ramps, predicted by a behavioural model of the ramp within the bench.
// Depends on acr_pkg, the three channel interfaces and adc_to_rgba_color_ramp_unit.
module tb;

  localparam int LATENCY     = 29;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 7;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_CYCLES = 300;

  // Register index of stop k.
  function automatic logic [acr_pkg::CFG_IDX_W-1:0] stop_reg(input int k);
    return acr_pkg::CFG_IDX_W'(int'(acr_pkg::REG_STOP_FIRST) + k);
  endfunction

  // Register indexes beyond the stop registers, which the block must ignore.
  localparam logic [acr_pkg::CFG_IDX_W-1:0] REG_PAST_STOPS = stop_reg(acr_pkg::MAX_STOPS);
  localparam logic [acr_pkg::CFG_IDX_W-1:0] REG_TOP        = '1;

  typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_PINNED} row_kind_t;

  typedef struct packed {
    row_kind_t                         kind;
    logic [acr_pkg::CFG_IDX_W-1:0]     index;
    logic [acr_pkg::CFG_DATA_W-1:0]    value;
    acr_pkg::color_t                   colour;
  } row_t;

  function automatic row_t wr(input logic [acr_pkg::CFG_IDX_W-1:0] idx,
                              input logic [acr_pkg::CFG_DATA_W-1:0] v);
    return '{kind: ROW_WRITE, index: idx, value: v, colour: '0};
  endfunction

  function automatic row_t px(input int s);
    return '{kind: ROW_SAMPLE, index: '0, value: acr_pkg::CFG_DATA_W'(s), colour: '0};
  endfunction

  function automatic row_t px_is(input int s, input logic [acr_pkg::COLOR_W-1:0] c);
    return '{kind: ROW_PINNED, index: '0, value: acr_pkg::CFG_DATA_W'(s),
             colour: acr_pkg::color_t'(c)};
  endfunction

  localparam int N_DIRECTED = 45;
  localparam row_t DIRECTED [N_DIRECTED] = '{
    // Default ramp after reset: black at 0.0, white at 1.0, full scale 4095.
    px_is(0, 32'h00000000),
    px_is(-32768, 32'h00000000),
    px_is(-1, 32'h00000000),
    px_is(4095, 32'hFFFFFFFF),
    px_is(32767, 32'hFFFFFFFF),
    px(1),
    px(2048),
    px(4094),
    // Stop count of zero acts as one stop; zero full scale acts as one.
    wr(acr_pkg::REG_STOP_COUNT, '0),
    wr(acr_pkg::REG_FULL_SCALE, '0),
    wr(acr_pkg::REG_STOP_FIRST, {17'h10000, 32'h12345678}),
    px_is(0, 32'h12345678),
    px_is(1, 32'h12345678),
    px_is(32767, 32'h12345678),
    px_is(-32768, 32'h12345678),
    // Count above the maximum clamps to six stops; largest full scale.
    wr(acr_pkg::REG_STOP_COUNT, acr_pkg::CFG_DATA_W'(7)),
    wr(acr_pkg::REG_FULL_SCALE, acr_pkg::CFG_DATA_W'(32767)),
    wr(stop_reg(0), {17'h00000, 32'h00FF00FF}),
    wr(stop_reg(1), {17'h04000, 32'hFF000080}),
    wr(stop_reg(2), {17'h08000, 32'h00FFFF00}),
    wr(stop_reg(3), {17'h0C000, 32'h12345678}),
    wr(stop_reg(4), {17'h10000, 32'hFFFFFFFF}),
    wr(stop_reg(5), {17'h1FFFF, 32'h00000000}),
    px_is(-32768, 32'h00FF00FF),
    px(8192),
    px(12345),
    px(24576),
    px(30000),
    px(32767),
    // Stops out of order, full scale of one, and writes to unused indexes.
    wr(acr_pkg::REG_FULL_SCALE, acr_pkg::CFG_DATA_W'(1)),
    wr(acr_pkg::REG_STOP_COUNT, acr_pkg::CFG_DATA_W'(5)),
    wr(stop_reg(0), {17'h08000, 32'hAABBCCDD}),
    wr(stop_reg(1), {17'h02000, 32'h11223344}),
    wr(stop_reg(2), {17'h18000, 32'h55667788}),
    wr(stop_reg(3), {17'h04000, 32'h99AABBCC}),
    wr(stop_reg(4), {17'h1C000, 32'hDDEEFF00}),
    wr(REG_PAST_STOPS, '1),
    wr(REG_TOP, '1),
    px_is(0, 32'hAABBCCDD),
    px(1),
    px_is(2, 32'hDDEEFF00),
    wr(acr_pkg::REG_FULL_SCALE, acr_pkg::CFG_DATA_W'(100)),
    px(50),
    px(150),
    px(170)
  };

  logic clk = 1'b0;
  logic rst;

  acr_cfg_if    cfg_bus ();
  acr_sample_if adc_bus ();
  acr_pixel_if  pix_bus ();

  adc_to_rgba_color_ramp_unit dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_bus),
    .adc   (adc_bus),
    .pixel (pix_bus)
  );

  always #2 clk = ~clk;

  // Shadow copy of the ramp registers, updated as each write is accepted.
  logic [acr_pkg::CNT_W-1:0] ramp_cnt   = acr_pkg::STOP_COUNT_RST;
  logic [acr_pkg::FS_W-1:0]  ramp_fs    = acr_pkg::FULL_SCALE_RST;
  acr_pkg::stop_t            ramp_stops [acr_pkg::MAX_STOPS] =
    '{0: '0, 1: acr_pkg::STOP_1_RST, default: '0};

  acr_pkg::color_t pending_pixels [$];
  int     errors = 0;
  int     cycles = 0;
  bit     calm = 1'b0;
  bit     hold_pending = 1'b0;

  // Colour that the ramp gives for one sample under the shadow registers.
  function automatic acr_pkg::color_t ramp_colour(input logic [acr_pkg::SAMPLE_W-1:0] s);
    longint unsigned fs, z, z0, z1, d, num, v;
    int n, k;
    acr_pkg::stop_t lo, hi;
    acr_pkg::color_t res;
    fs = (ramp_fs == '0) ? 64'd1 : 64'(ramp_fs);
    n = int'(ramp_cnt);
    if (n < 1) n = 1;
    if (n > acr_pkg::MAX_STOPS) n = acr_pkg::MAX_STOPS;
    if (s[acr_pkg::SAMPLE_W-1]) begin
      z = 0;
    end else begin
      z = (64'(s) << acr_pkg::POS_FRAC_BITS) / fs;
      if (z > 64'(acr_pkg::POS_MAX)) z = 64'(acr_pkg::POS_MAX);
    end
    if (z <= 64'(ramp_stops[0].pos)) return ramp_stops[0].color;
    if (z >= 64'(ramp_stops[n-1].pos)) return ramp_stops[n-1].color;
    // First stop at or above the position bounds the segment from above.
    k = 1;
    while (k < n - 1 && 64'(ramp_stops[k].pos) < z) k++;
    lo = ramp_stops[k-1];
    hi = ramp_stops[k];
    z0 = 64'(lo.pos);
    z1 = 64'(hi.pos);
    d  = z1 - z0;
    for (int c = 0; c < acr_pkg::NUM_CHANS; c++) begin
      num = 64'(lo.color[c]) * (z1 - z) + 64'(hi.color[c]) * (z - z0);
      v = (64'd2 * num + d) / (64'd2 * d);
      res[c] = (v > 64'd255) ? 8'hFF : v[acr_pkg::CHAN_W-1:0];
    end
    return res;
  endfunction

  // Offer one sample and wait until the block takes it.
  task automatic send_sample(input logic [acr_pkg::SAMPLE_W-1:0] s, input bit pinned,
                             input acr_pkg::color_t want);
    adc_bus.valid  <= 1'b1;
    adc_bus.sample <= s;
    @(posedge clk);
    while (!adc_bus.ready) @(posedge clk);
    pending_pixels.push_back(pinned ? want : ramp_colour(s));
  endtask

  // Random gap on the sample side between items.
  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 3) == 0) begin
      adc_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Stop offering samples until every expected pixel has come out.
  task automatic wait_drained();
    adc_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  task automatic write_reg(input logic [acr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [acr_pkg::CFG_DATA_W-1:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == acr_pkg::REG_STOP_COUNT) begin
      ramp_cnt = v[acr_pkg::CNT_W-1:0];
    end else if (idx == acr_pkg::REG_FULL_SCALE) begin
      ramp_fs = v[acr_pkg::FS_W-1:0];
    end else if (idx >= acr_pkg::REG_STOP_FIRST && idx < REG_PAST_STOPS) begin
      ramp_stops[idx - acr_pkg::REG_STOP_FIRST] = acr_pkg::stop_t'(v);
    end
  endtask

  // Sample side: reset, directed table, then randomised ramps.
  initial begin
    int s, fs_eff, j;
    longint t;
    bit ascending;
    int unsigned pos_q [$];
    rst            <= 1'b1;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= '0;
    cfg_bus.data   <= '0;
    adc_bus.valid  <= 1'b0;
    adc_bus.sample <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIRECTED; r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        if (r > 0 && DIRECTED[r-1].kind != ROW_WRITE) wait_drained();
        write_reg(DIRECTED[r].index, DIRECTED[r].value);
      end else begin
        if (r > 0 && DIRECTED[r-1].kind == ROW_WRITE) cfg_bus.valid <= 1'b0;
        send_sample(DIRECTED[r].value[acr_pkg::SAMPLE_W-1:0],
                    DIRECTED[r].kind == ROW_PINNED, DIRECTED[r].colour);
        maybe_idle();
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      calm = (ph == RAND_PHASES - 1);

      // New ramp: mostly ascending stops, now and then in random order.
      write_reg(acr_pkg::REG_STOP_COUNT, acr_pkg::CFG_DATA_W'($urandom_range(0, 7)));
      case ($urandom_range(0, 4))
        0: write_reg(acr_pkg::REG_FULL_SCALE, acr_pkg::CFG_DATA_W'($urandom_range(1, 64)));
        1: write_reg(acr_pkg::REG_FULL_SCALE, acr_pkg::CFG_DATA_W'(32767));
        2: write_reg(acr_pkg::REG_FULL_SCALE, acr_pkg::CFG_DATA_W'(1));
        default: begin
          write_reg(acr_pkg::REG_FULL_SCALE,
                    acr_pkg::CFG_DATA_W'($urandom_range(1, 32767)));
        end
      endcase
      ascending = ($urandom_range(0, 3) != 0);
      pos_q.delete();
      for (j = 0; j < acr_pkg::MAX_STOPS; j++) begin
        pos_q.push_back($urandom_range(0, int'(acr_pkg::POS_MAX)));
      end
      if (ascending) begin
        pos_q.sort();
        if ($urandom_range(0, 1) == 1) begin
          pos_q[0] = 0;
          pos_q[acr_pkg::MAX_STOPS-1] = int'(acr_pkg::POS_MAX);
        end
      end
      for (j = 0; j < acr_pkg::MAX_STOPS; j++) begin
        write_reg(stop_reg(j), {acr_pkg::pos_t'(pos_q[j]), 32'($urandom)});
      end
      write_reg(acr_pkg::CFG_IDX_W'($urandom_range(int'(REG_PAST_STOPS), int'(REG_TOP))),
                acr_pkg::CFG_DATA_W'({$urandom, $urandom}));
      cfg_bus.valid <= 1'b0;
      fs_eff = (ramp_fs == '0) ? 1 : int'(ramp_fs);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Long output stall while samples keep coming, then a full drain.
        if (ph == 2 && k == 20) hold_pending = 1'b1;
        if (ph == 4 && k == 50) wait_drained();
        case ($urandom_range(0, 9))
          0, 1: s = $urandom_range(0, 65535);
          2:    s = -int'($urandom_range(1, 32768));
          3, 4: begin
            // Close to a stop, where the segment choice changes.
            j = $urandom_range(0, acr_pkg::MAX_STOPS - 1);
            t = (longint'(ramp_stops[j].pos) * fs_eff) >>> acr_pkg::POS_FRAC_BITS;
            t = t + $urandom_range(0, 2) - 1;
            if (t < 0) t = 0;
            if (t > 32767) t = 32767;
            s = int'(t);
          end
          default: s = $urandom_range(0, (2 * fs_eff + 1 > 32767) ? 32767 : 2 * fs_eff + 1);
        endcase
        send_sample(acr_pkg::SAMPLE_W'(s), 1'b0, '0);
        maybe_idle();
      end
    end

    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Pixel side: random back-pressure, one long hold-off, none at the end.
  initial begin
    pix_bus.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        pix_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        pix_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        pix_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Compare each pixel taken with the oldest expected colour.
  always @(posedge clk) begin
    acr_pkg::color_t want;
    acr_pkg::color_t got;
    string  chan_name [acr_pkg::NUM_CHANS];
    chan_name = '{"red", "green", "blue", "alpha"};
    if (!rst && pix_bus.valid && pix_bus.ready) begin
      got = {pix_bus.red, pix_bus.green, pix_bus.blue, pix_bus.alpha};
      if (pending_pixels.size() == 0) begin
        $error("pixel with no expected item: %h", got);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        for (int c = 0; c < acr_pkg::NUM_CHANS; c++) begin
          if (got[c] !== want[c]) begin
            $error("%s mismatch: expected %0d, got %0d",
                   chan_name[acr_pkg::NUM_CHANS-1-c], want[c], got[c]);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
